/* hdl/cbu_pkg.sv */
// Shared types and constants of the bilinear 4:2:0 chroma upsampler.
package cbu_pkg;

  // Fixed widths set by the interface fields.
  localparam int CFG_BITS        = 13;
  localparam int CFG_IDX_BITS    = 1;
  localparam int POS_BITS        = 12;
  localparam int ROW_CNT_BITS    = 11;
  localparam int IN_BITS         = 12;
  localparam int SAMPLE_MAX_BITS = 15;
  localparam int HEIGHT_CAP      = 4096;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH     = 4;
  localparam int QUEUE_PTR_BITS  = 2;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_OUT_WIDTH  = 1'b0,
    CFG_OUT_HEIGHT = 1'b1
  } cfg_idx_t;

  // Position of an output row or column relative to twice the input index:
  // one before, on it, or one after.
  typedef enum logic [1:0] {
    PH_PREV = 2'd0,
    PH_NEAR = 2'd1,
    PH_NEXT = 2'd2
  } phase_t;

  // One classified input item: its 2x2 neighborhood and the output window.
  typedef struct packed {
    logic [SAMPLE_MAX_BITS-1:0] v00;
    logic [SAMPLE_MAX_BITS-1:0] v01;
    logic [SAMPLE_MAX_BITS-1:0] v10;
    logic [SAMPLE_MAX_BITS-1:0] v11;
    logic [POS_BITS-1:0]        row_base;
    logic [POS_BITS-1:0]        col_base;
    phase_t                     rp_start;
    phase_t                     rp_end;
    phase_t                     cp_start;
    phase_t                     cp_end;
  } desc_t;

  // Handshake between the queue and its neighbors.
  typedef struct packed {
    logic full;
    logic nempty;
  } q_stat_t;

endpackage

/* hdl/cbu_front.sv */
// Front end: input acceptance, position tracking, line store and classification.
module cbu_front #(
  parameter int MAX_OUT_W   = 4096,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [cbu_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [cbu_pkg::CFG_BITS-1:0]      cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [cbu_pkg::IN_BITS-1:0]       in_chroma_in,
  input  cbu_pkg::q_stat_t                  q_stat,
  output logic                              q_push,
  output cbu_pkg::desc_t                    q_wdata
);

  localparam int LINE_DEPTH = (MAX_OUT_W + 1) / 2;
  localparam int CW  = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int WB  = $clog2(MAX_OUT_W + 1);
  localparam int EW  = (WB > cbu_pkg::CFG_BITS) ? WB : cbu_pkg::CFG_BITS;
  localparam int RW  = cbu_pkg::ROW_CNT_BITS;
  localparam int HW  = cbu_pkg::CFG_BITS;
  localparam int SMB = cbu_pkg::SAMPLE_MAX_BITS;
  localparam int PB  = cbu_pkg::POS_BITS;

  logic [HW-1:0] width_r;
  logic [HW-1:0] height_r;

  logic [EW-1:0] w_lim;
  logic [HW-1:0] h_lim;
  logic [CW-1:0] inw_m1;
  logic [RW-1:0] inh_m1;

  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_cur;
  logic [CW-1:0] col_cur;
  logic          last_row, last_col;
  logic          accept;

  logic [SAMPLE_BITS-1:0] line_mem [LINE_DEPTH];
  logic [SAMPLE_BITS-1:0] rd_r;
  logic [SAMPLE_BITS-1:0] smp;

  logic                   s1_v_r;
  logic [SAMPLE_BITS-1:0] s1_smp_r;
  logic [RW-1:0]          s1_row_r;
  logic [CW-1:0]          s1_col_r;
  logic                   s1_top_r;
  logic                   s1_lft_r;
  cbu_pkg::phase_t        s1_rpe_r;
  cbu_pkg::phase_t        s1_cpe_r;

  logic [SAMPLE_BITS-1:0] left_r;
  logic [SAMPLE_BITS-1:0] ul_r;
  logic [SAMPLE_BITS-1:0] v00, v01, v10, v11;

  // Effective frame size: zero counts as one, oversize is capped.
  always_comb begin
    if (width_r == '0) begin
      w_lim = EW'(1);
    end else if (EW'(width_r) > EW'(MAX_OUT_W)) begin
      w_lim = EW'(MAX_OUT_W);
    end else begin
      w_lim = EW'(width_r);
    end
    if (height_r == '0) begin
      h_lim = HW'(1);
    end else if (height_r > HW'(cbu_pkg::HEIGHT_CAP)) begin
      h_lim = HW'(cbu_pkg::HEIGHT_CAP);
    end else begin
      h_lim = height_r;
    end
    inw_m1 = CW'((({1'b0, w_lim} + (EW+1)'(1)) >> 1) - (EW+1)'(1));
    inh_m1 = RW'((({1'b0, h_lim} + (HW+1)'(1)) >> 1) - (HW+1)'(1));
  end

  // A position outside the plane restarts at the origin.
  always_comb begin
    if (row_r > inh_m1 || col_r > inw_m1) begin
      row_cur = '0;
      col_cur = '0;
    end else begin
      row_cur = row_r;
      col_cur = col_r;
    end
    last_row = (row_cur == inh_m1);
    last_col = (col_cur == inw_m1);
    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : row_cur + RW'(1);
    end else begin
      col_nxt = col_cur + CW'(1);
      row_nxt = row_cur;
    end
  end

  assign smp      = SAMPLE_BITS'(in_chroma_in);
  assign q_push   = s1_v_r && !q_stat.full;
  assign in_stall = s1_v_r && q_stat.full;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= HW'(4096);
      height_r <= HW'(4096);
      row_r    <= '0;
      col_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        cbu_pkg::CFG_OUT_WIDTH:  width_r  <= cfg_wdata;
        cbu_pkg::CFG_OUT_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
      row_r <= '0;
      col_r <= '0;
    end else if (accept) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // Line store: the read returns the previous row's sample before it is replaced.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r              <= line_mem[col_cur];
      line_mem[col_cur] <= smp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (accept) begin
      s1_v_r <= 1'b1;
    end else if (q_push) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_smp_r <= smp;
      s1_row_r <= row_cur;
      s1_col_r <= col_cur;
      s1_top_r <= (row_cur == '0);
      s1_lft_r <= (col_cur == '0);
      s1_rpe_r <= (last_row && !h_lim[0]) ? cbu_pkg::PH_NEXT : cbu_pkg::PH_NEAR;
      s1_cpe_r <= (last_col && !w_lim[0]) ? cbu_pkg::PH_NEXT : cbu_pkg::PH_NEAR;
    end
  end

  // Edge-clamped 2x2 neighborhood.
  always_comb begin
    v11 = s1_smp_r;
    v10 = s1_lft_r ? v11 : left_r;
    v01 = s1_top_r ? v11 : rd_r;
    v00 = s1_top_r ? v10 : (s1_lft_r ? v01 : ul_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
      ul_r   <= '0;
    end else if (q_push) begin
      left_r <= v11;
      ul_r   <= v01;
    end
  end

  always_comb begin
    q_wdata.v00      = SMB'(v00);
    q_wdata.v01      = SMB'(v01);
    q_wdata.v10      = SMB'(v10);
    q_wdata.v11      = SMB'(v11);
    q_wdata.row_base = PB'({s1_row_r, 1'b0});
    q_wdata.col_base = PB'({s1_col_r, 1'b0});
    q_wdata.rp_start = s1_top_r ? cbu_pkg::PH_NEAR : cbu_pkg::PH_PREV;
    q_wdata.rp_end   = s1_rpe_r;
    q_wdata.cp_start = s1_lft_r ? cbu_pkg::PH_NEAR : cbu_pkg::PH_PREV;
    q_wdata.cp_end   = s1_cpe_r;
  end

endmodule

/* hdl/cbu_queue.sv */
// Short descriptor queue between the front end and the back end.
module cbu_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  cbu_pkg::desc_t   wdata,
  input  logic             pop,
  output cbu_pkg::desc_t   rdata,
  output cbu_pkg::q_stat_t stat
);

  localparam int PW = cbu_pkg::QUEUE_PTR_BITS;
  localparam int DEPTH = cbu_pkg::QUEUE_DEPTH;

  cbu_pkg::desc_t  slots_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [PW:0]     count_r;

  assign stat.full   = (count_r == (PW+1)'(DEPTH));
  assign stat.nempty = (count_r != '0);
  assign rdata       = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (PW+1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (PW+1)'(1);
      end
    end
  end

endmodule

/* hdl/cbu_back.sv */
// Back end: interpolates each descriptor's output window, one sample a cycle if unstalled.
module cbu_back #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cbu_pkg::q_stat_t              q_stat,
  input  cbu_pkg::desc_t                q_rdata,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [cbu_pkg::POS_BITS-1:0]  out_row,
  output logic [cbu_pkg::POS_BITS-1:0]  out_col,
  output logic [cbu_pkg::IN_BITS-1:0]   out_chroma_out,
  output logic                          out_run_last
);

  localparam int PB = cbu_pkg::POS_BITS;
  localparam int SW = SAMPLE_BITS + 4;

  cbu_pkg::desc_t  cur_r;
  logic            cur_v_r;
  cbu_pkg::phase_t rp_r;
  cbu_pkg::phase_t cp_r;

  logic out_free, emit, row_end, win_end, load;
  logic rn, rf, cn, cf;
  logic [SAMPLE_BITS-1:0] a, b, c, d;
  logic [SW-1:0] sum;

  logic              out_valid_r;
  logic [PB-1:0]     row_r, col_r;
  logic [SAMPLE_BITS-1:0] val_r;
  logic              last_r;

  // Select a neighborhood sample; a set flag picks the current row or column.
  function automatic logic [SAMPLE_BITS-1:0] pick(input cbu_pkg::desc_t ds,
                                                  input logic rsel, input logic csel);
    logic [SAMPLE_BITS-1:0] res;
    case ({rsel, csel})
      2'b11:   res = SAMPLE_BITS'(ds.v11);
      2'b10:   res = SAMPLE_BITS'(ds.v10);
      2'b01:   res = SAMPLE_BITS'(ds.v01);
      default: res = SAMPLE_BITS'(ds.v00);
    endcase
    return res;
  endfunction

  assign out_free = !out_valid_r || !out_stall;
  assign emit     = cur_v_r && out_free;
  assign row_end  = (cp_r == cur_r.cp_end);
  assign win_end  = row_end && (rp_r == cur_r.rp_end);
  assign load     = q_stat.nempty && (!cur_v_r || (emit && win_end));
  assign q_pop    = load;

  always_comb begin
    rn  = (rp_r != cbu_pkg::PH_PREV);
    rf  = (rp_r != cbu_pkg::PH_NEAR);
    cn  = (cp_r != cbu_pkg::PH_PREV);
    cf  = (cp_r != cbu_pkg::PH_NEAR);
    a   = pick(cur_r, rn, cn);
    b   = pick(cur_r, rn, cf);
    c   = pick(cur_r, rf, cn);
    d   = pick(cur_r, rf, cf);
    // 9a + 3b + 3c + d
    sum = (SW'(a) << 3) + SW'(a) + (SW'(b) << 1) + SW'(b)
        + (SW'(c) << 1) + SW'(c) + SW'(d);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r <= 1'b0;
    end else if (load) begin
      cur_v_r <= 1'b1;
    end else if (emit && win_end) begin
      cur_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_r <= q_rdata;
      rp_r  <= q_rdata.rp_start;
      cp_r  <= q_rdata.cp_start;
    end else if (emit) begin
      if (row_end) begin
        cp_r <= cur_r.cp_start;
        rp_r <= cbu_pkg::phase_t'(rp_r + 2'd1);
      end else begin
        cp_r <= cbu_pkg::phase_t'(cp_r + 2'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      row_r  <= cur_r.row_base + PB'(rp_r) - PB'(1);
      col_r  <= cur_r.col_base + PB'(cp_r) - PB'(1);
      val_r  <= SAMPLE_BITS'((sum + SW'(8)) >> 4);
      last_r <= win_end;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_row        = row_r;
  assign out_col        = col_r;
  assign out_chroma_out = cbu_pkg::IN_BITS'(val_r);
  assign out_run_last   = last_r;

endmodule

/* hdl/chroma_bilinear_upsample_420_top.sv */
// A transaction's first result passes the front-end stage register, a queue slot, the
// back-end descriptor register and its single output register stage. The back end gives
// one result per cycle while out_stall is low; a transaction with n results (1 to 9)
// keeps it busy till all n are out. The front end takes one transaction per cycle while
// the four-entry queue has room. Reset is synchronous and active low; it clears control
// state and the frame position; the line store keeps its contents, needing no clearing.
module chroma_bilinear_upsample_420_top #(
  parameter int MAX_OUT_W   = 4096,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration write port: index 0 is out_width, index 1 is out_height.
  input  logic                              cfg_we,
  input  logic [cbu_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [cbu_pkg::CFG_BITS-1:0]      cfg_wdata,
  // Half-resolution input samples in raster order.
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [cbu_pkg::IN_BITS-1:0]       in_chroma_in,
  // Full-resolution interpolated samples.
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [cbu_pkg::POS_BITS-1:0]      out_row,
  output logic [cbu_pkg::POS_BITS-1:0]      out_col,
  output logic [cbu_pkg::IN_BITS-1:0]       out_chroma_out,
  output logic                              out_run_last
);

  // The front end tracks the input position, keeps the previous input row in
  // the line store, gathers the edge-clamped 2x2 neighborhood of every input
  // sample and works out which output rows and columns that sample completes.
  // Each classified transaction becomes one descriptor in the queue.
  cbu_pkg::desc_t   q_wdata;
  cbu_pkg::desc_t   q_rdata;
  cbu_pkg::q_stat_t q_stat;
  logic             q_push;
  logic             q_pop;

  cbu_front #(
    .MAX_OUT_W   (MAX_OUT_W),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_chroma_in (in_chroma_in),
    .q_stat       (q_stat),
    .q_push       (q_push),
    .q_wdata      (q_wdata)
  );

  // The queue decouples the two halves so that a stalled result channel does
  // not immediately stall the input, and bursts of nine-result transactions
  // are absorbed while single-result transactions keep flowing.
  cbu_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  // The back end steps through the output window of each descriptor in raster
  // order, applies the 9/3/3/1 weights with round-half-up, and flags the last
  // result of each transaction. Its output register separates it from the
  // consumer, and the next descriptor is loaded as the current one finishes.
  cbu_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_stat         (q_stat),
    .q_rdata        (q_rdata),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_chroma_out (out_chroma_out),
    .out_run_last   (out_run_last)
  );

endmodule
